FILE: rtl/fpr_pkg.sv
package fpr_pkg;

  // Result kinds as they appear on the output tuser.
  typedef enum logic [1:0] {
    KIND_FRAME    = 2'd0,
    KIND_OVERSIZE = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_TIMEOUT  = 2'd3
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SYNC    = 2'd0,
    REG_OWN     = 2'd1,
    REG_BCAST   = 2'd2,
    REG_TIMEOUT = 2'd3
  } cfg_reg_e;

  // Field widths.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned CHECK_W  = 16;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Internal frame length holds up to the largest payload limit (64).
  localparam int unsigned FLEN_W   = 7;
  // Payload store address wide enough for the largest payload limit.
  localparam int unsigned STORE_AW = 6;

  localparam logic [LEN_W-1:0]  LEN_SAT  = 6'h3F;
  localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

  // Output tdata width: 59 field bits padded to whole bytes.
  localparam int unsigned OUT_DATA_W = 64;

  // One job handed from the parser to the result generator.
  typedef struct packed {
    kind_e                kind;
    logic [BYTE_W-1:0]    sender;
    logic [BYTE_W-1:0]    target;
    logic [BYTE_W-1:0]    command;
    logic [LEN_W-1:0]     length;
    logic [CHECK_W-1:0]   check;
    logic                 drain;      // one result per stored payload byte
    logic [FLEN_W-1:0]    drain_len;
  } job_t;

  // Payload store write port.
  typedef struct packed {
    logic                 en;
    logic [STORE_AW-1:0]  addr;
    logic [BYTE_W-1:0]    data;
  } store_wr_t;

  // One result item.
  typedef struct packed {
    kind_e                kind;
    logic [BYTE_W-1:0]    sender;
    logic [BYTE_W-1:0]    target;
    logic [BYTE_W-1:0]    command;
    logic [LEN_W-1:0]     length;
    logic [IDX_W-1:0]     byte_index;
    logic [BYTE_W-1:0]    payload_byte;
    logic [CHECK_W-1:0]   check_word;
    logic                 last;
  } out_item_t;

endpackage

FILE: rtl/fpr_front.sv
module fpr_front #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration writes.
  input  logic                               cfg_valid_i,
  input  logic [fpr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fpr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Incoming items.
  input  logic                               in_valid_i,
  input  logic                               in_op_i,
  input  logic [fpr_pkg::BYTE_W-1:0]         in_byte_i,
  output logic                               in_ready_o,
  // Job queue push side.
  input  logic                               q_full_i,
  output logic                               push_o,
  output fpr_pkg::job_t                      push_job_o,
  // Payload store writes and drain completion.
  output fpr_pkg::store_wr_t                 wr_o,
  input  logic                               drain_done_i
);

  typedef enum logic [3:0] {
    PH_HUNT, PH_SENDER, PH_TARGET, PH_CMD, PH_LEN, PH_DATA, PH_CHK_HI, PH_CHK_LO
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [fpr_pkg::BYTE_W-1:0]      sync_q, own_q, bcast_q;
  logic [fpr_pkg::TICK_W-1:0]      timeout_q;
  logic [fpr_pkg::BYTE_W-1:0]      sender_q, sender_d;
  logic [fpr_pkg::BYTE_W-1:0]      target_q, target_d;
  logic [fpr_pkg::BYTE_W-1:0]      command_q, command_d;
  logic [fpr_pkg::FLEN_W-1:0]      flen_q, flen_d;
  logic [fpr_pkg::FLEN_W-1:0]      rcvd_q, rcvd_d;
  logic [fpr_pkg::BYTE_W-1:0]      chk_hi_q, chk_hi_d;
  logic [fpr_pkg::TICK_W-1:0]      elapsed_q, elapsed_d;
  logic                            busy_q, busy_d;

  logic                            accept;
  logic [fpr_pkg::TICK_W-1:0]      elapsed_inc;
  logic [fpr_pkg::FLEN_W-1:0]      rcvd_inc;
  logic                            oversize;
  logic                            addr_match;

  // Stall while a payload byte is due and the store still drains the previous frame, or the queue is full.
  assign in_ready_o = !q_full_i && !((phase_q == PH_DATA) && busy_q);
  assign accept     = in_valid_i && in_ready_o;

  assign elapsed_inc = (elapsed_q == fpr_pkg::TICK_MAX) ? elapsed_q : elapsed_q + 1'b1;
  assign rcvd_inc    = rcvd_q + 1'b1;
  assign oversize    = {1'b0, in_byte_i} > 9'(MAX_PAYLOAD);
  assign addr_match  = (target_q == own_q) || (target_q == bcast_q);

  // Payload bytes go to the store at the running byte count.
  always_comb begin
    wr_o.en   = accept && !in_op_i && (phase_q == PH_DATA);
    wr_o.addr = rcvd_q[fpr_pkg::STORE_AW-1:0];
    wr_o.data = in_byte_i;
  end

  // Frame parser and job classification.
  always_comb begin
    phase_d    = phase_q;
    sender_d   = sender_q;
    target_d   = target_q;
    command_d  = command_q;
    flen_d     = flen_q;
    rcvd_d     = rcvd_q;
    chk_hi_d   = chk_hi_q;
    elapsed_d  = elapsed_q;
    push_o     = 1'b0;
    push_job_o.kind      = fpr_pkg::KIND_FRAME;
    push_job_o.sender    = sender_q;
    push_job_o.target    = target_q;
    push_job_o.command   = command_q;
    push_job_o.length    = flen_q[fpr_pkg::LEN_W-1:0];
    push_job_o.check     = '0;
    push_job_o.drain     = 1'b0;
    push_job_o.drain_len = flen_q;

    if (accept) begin
      if (in_op_i) begin
        // Time tick: only counts while a frame is open.
        if (phase_q != PH_HUNT) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc > timeout_q) begin
            push_o          = 1'b1;
            push_job_o.kind = fpr_pkg::KIND_TIMEOUT;
            phase_d         = PH_HUNT;
          end
        end
      end else begin
        unique case (phase_q)
          PH_HUNT: begin
            if (in_byte_i == sync_q) begin
              sender_d  = '0;
              target_d  = '0;
              command_d = '0;
              flen_d    = '0;
              rcvd_d    = '0;
              chk_hi_d  = '0;
              elapsed_d = '0;
              phase_d   = PH_SENDER;
            end
          end
          PH_SENDER: begin
            sender_d = in_byte_i;
            phase_d  = PH_TARGET;
          end
          PH_TARGET: begin
            target_d = in_byte_i;
            phase_d  = PH_CMD;
          end
          PH_CMD: begin
            command_d = in_byte_i;
            phase_d   = PH_LEN;
          end
          PH_LEN: begin
            if (oversize) begin
              push_o            = 1'b1;
              push_job_o.kind   = fpr_pkg::KIND_OVERSIZE;
              push_job_o.length = (in_byte_i > fpr_pkg::BYTE_W'(fpr_pkg::LEN_SAT)) ?
                                  fpr_pkg::LEN_SAT : in_byte_i[fpr_pkg::LEN_W-1:0];
              phase_d           = PH_HUNT;
            end else begin
              flen_d  = in_byte_i[fpr_pkg::FLEN_W-1:0];
              rcvd_d  = '0;
              phase_d = (in_byte_i == '0) ? PH_CHK_HI : PH_DATA;
            end
          end
          PH_DATA: begin
            rcvd_d = rcvd_inc;
            if (rcvd_inc >= flen_q) begin
              phase_d = PH_CHK_HI;
            end
          end
          PH_CHK_HI: begin
            chk_hi_d = in_byte_i;
            phase_d  = PH_CHK_LO;
          end
          PH_CHK_LO: begin
            push_o           = 1'b1;
            push_job_o.check = {chk_hi_q, in_byte_i};
            phase_d          = PH_HUNT;
            if (!addr_match) begin
              push_job_o.kind = fpr_pkg::KIND_MISMATCH;
            end else if (flen_q != '0) begin
              push_job_o.drain = 1'b1;
            end
          end
          default: phase_d = PH_HUNT;
        endcase
      end
    end

    // The store is owned by a drain job from its push until its last read.
    busy_d = (busy_q && !drain_done_i) || (push_o && push_job_o.drain);
  end

  // State, frame fields and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      sender_q  <= '0;
      target_q  <= '0;
      command_q <= '0;
      flen_q    <= '0;
      rcvd_q    <= '0;
      chk_hi_q  <= '0;
      elapsed_q <= '0;
      busy_q    <= 1'b0;
      sync_q    <= 8'd85;
      own_q     <= 8'd1;
      bcast_q   <= 8'd255;
      timeout_q <= 16'd1000;
    end else begin
      phase_q   <= phase_d;
      sender_q  <= sender_d;
      target_q  <= target_d;
      command_q <= command_d;
      flen_q    <= flen_d;
      rcvd_q    <= rcvd_d;
      chk_hi_q  <= chk_hi_d;
      elapsed_q <= elapsed_d;
      busy_q    <= busy_d;
      if (cfg_valid_i) begin
        unique case (fpr_pkg::cfg_reg_e'(cfg_index_i))
          fpr_pkg::REG_SYNC:    sync_q    <= cfg_data_i[fpr_pkg::BYTE_W-1:0];
          fpr_pkg::REG_OWN:     own_q     <= cfg_data_i[fpr_pkg::BYTE_W-1:0];
          fpr_pkg::REG_BCAST:   bcast_q   <= cfg_data_i[fpr_pkg::BYTE_W-1:0];
          fpr_pkg::REG_TIMEOUT: timeout_q <= cfg_data_i[fpr_pkg::TICK_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: rtl/fpr_job_fifo.sv
module fpr_job_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fpr_pkg::job_t  push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output fpr_pkg::job_t  pop_job_o
);

  // Two-entry queue of jobs between the parser and the result generator.
  fpr_pkg::job_t  slot_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     count_q;
  logic           do_push, do_pop;

  assign full_o    = (count_q == 2'd2);
  assign valid_o   = (count_q != 2'd0);
  assign pop_job_o = slot_q[rptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= !wptr_q;
      end
      if (do_pop) begin
        rptr_q <= !rptr_q;
      end
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_job_i;
    end
  end

endmodule

FILE: rtl/fpr_back.sv
module fpr_back #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Job queue pop side.
  input  logic                 q_valid_i,
  input  fpr_pkg::job_t        q_job_i,
  output logic                 pop_o,
  // Payload store writes from the parser.
  input  fpr_pkg::store_wr_t   wr_i,
  output logic                 drain_done_o,
  // Result items.
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fpr_pkg::out_item_t   out_item_o
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [fpr_pkg::BYTE_W-1:0]  store_q [MAX_PAYLOAD];

  logic                        valid_q, valid_d;
  logic                        active_q, active_d;
  logic [fpr_pkg::FLEN_W-1:0]  idx_q;
  fpr_pkg::job_t               cur_job_q;

  // Output register contents.
  fpr_pkg::job_t               o_job_q;
  logic [fpr_pkg::IDX_W-1:0]   o_idx_q;
  logic                        o_last_q;
  logic                        o_pay_q;
  logic [fpr_pkg::BYTE_W-1:0]  rd_data_q;

  logic                        out_free;
  logic                        load;
  logic                        is_drain;
  logic                        item_last;
  fpr_pkg::job_t               job;
  logic [fpr_pkg::FLEN_W-1:0]  idx;
  logic [fpr_pkg::FLEN_W-1:0]  idx_inc;

  // Pick the next item: continue a drain, else start the next job.
  always_comb begin
    out_free  = !valid_q || out_ready_i;
    pop_o     = out_free && !active_q && q_valid_i;
    load      = (out_free && active_q) || pop_o;
    job       = active_q ? cur_job_q : q_job_i;
    idx       = active_q ? idx_q : '0;
    idx_inc   = idx + 1'b1;
    is_drain  = active_q || q_job_i.drain;
    item_last = is_drain ? (idx_inc == job.drain_len) : 1'b1;

    drain_done_o = load && is_drain && item_last;
    active_d     = active_q;
    valid_d      = valid_q;
    if (load) begin
      active_d = is_drain && !item_last;
      valid_d  = 1'b1;
    end else if (out_free) begin
      valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      active_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      active_q <= active_d;
    end
  end

  // Payload store, drain position and output register contents.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      store_q[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
    if (pop_o) begin
      cur_job_q <= q_job_i;
    end
    if (load) begin
      idx_q    <= idx_inc;
      o_job_q  <= job;
      o_idx_q  <= is_drain ? idx[fpr_pkg::IDX_W-1:0] : '0;
      o_last_q <= item_last;
      o_pay_q  <= is_drain;
      if (is_drain) begin
        rd_data_q <= store_q[idx[AW-1:0]];
      end
    end
  end

  assign out_valid_o = valid_q;

  // Result fields; the payload byte reads as zero outside a drain.
  always_comb begin
    out_item_o.kind         = o_job_q.kind;
    out_item_o.sender       = o_job_q.sender;
    out_item_o.target       = o_job_q.target;
    out_item_o.command      = o_job_q.command;
    out_item_o.length       = o_job_q.length;
    out_item_o.byte_index   = o_idx_q;
    out_item_o.payload_byte = o_pay_q ? rd_data_q : '0;
    out_item_o.check_word   = o_job_q.check;
    out_item_o.last         = o_last_q;
  end

endmodule

FILE: rtl/framed_packet_receiver.sv
// Channel   | Direction | Handshake                   | Payload
// ----------+-----------+-----------------------------+----------------------------------
// s_axis    | in        | s_axis_tvalid/s_axis_tready | tdata: rx_byte; tuser: op
// m_axis    | out       | m_axis_tvalid/m_axis_tready | tdata: frame fields; tuser: kind;
//           |           |                             | tlast: last
// cfg       | in        | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i
//
// The parser takes one item per cycle; results leave at one per cycle while m_axis_tready
// is high. A matching frame with N > 0 payload bytes yields N results from the payload
// store; other jobs yield one. Input stalls while the store is still draining and a new
// payload byte is due, or while the two-entry job queue is full. Reset clears parser and
// output state; the payload store has no reset and needs no clearing pass.
module framed_packet_receiver #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [7:0] rx_byte
  input  logic                                s_axis_tuser,  // [0] op
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] sender, [15:8] target, [23:16] command, [29:24] length,
  // [34:30] byte_index, [42:35] payload_byte, [58:43] check_word, [63:59] zero
  output logic [fpr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [1:0]                          m_axis_tuser,  // [1:0] kind
  output logic                                m_axis_tlast,
  // Configuration writes.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fpr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fpr_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  logic                 q_full, q_push, q_valid, q_pop;
  fpr_pkg::job_t        push_job, pop_job;
  fpr_pkg::store_wr_t   store_wr;
  logic                 drain_done;
  fpr_pkg::out_item_t   item;

  assign cfg_ready_o = 1'b1;

  fpr_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_op_i      (s_axis_tuser),
    .in_byte_i    (s_axis_tdata),
    .in_ready_o   (s_axis_tready),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .push_job_o   (push_job),
    .wr_o         (store_wr),
    .drain_done_i (drain_done)
  );

  fpr_job_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_job_o  (pop_job)
  );

  fpr_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_job_i      (pop_job),
    .pop_o        (q_pop),
    .wr_i         (store_wr),
    .drain_done_o (drain_done),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_item_o   (item)
  );

  // Pack the result fields onto the stream.
  assign m_axis_tdata = {5'b0, item.check_word, item.payload_byte, item.byte_index,
                         item.length, item.command, item.target, item.sender};
  assign m_axis_tuser = item.kind;
  assign m_axis_tlast = item.last;

endmodule

FILE: rtl/fpr_checker.sv
module fpr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast
);

  // A stalled result holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Drops and timeouts are single results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != fpr_pkg::KIND_FRAME) |-> m_axis_tlast)
    else $error("non-frame result not marked last");

  // Only frame items carry a byte index or payload byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != fpr_pkg::KIND_FRAME) |-> m_axis_tdata[42:30] == '0)
    else $error("payload fields set on a drop result");

  // Oversize and timeout results carry no check word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser == fpr_pkg::KIND_OVERSIZE) ||
                      (m_axis_tuser == fpr_pkg::KIND_TIMEOUT))
    |-> m_axis_tdata[58:43] == '0)
    else $error("check word set on an abandoned frame");

endmodule

bind framed_packet_receiver fpr_checker u_fpr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
